>>> rtl/alist_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Adjacency list package
// Field widths, default sizes, command and status codes shared by the
// interfaces and the edge store.
// ----------------------------------------------------------------------------
package alist_pkg;

   // Default sizes handed to the top level parameters.
   localparam int NODES_DEF       = 64;
   localparam int MAX_DEGREE_DEF  = 16;
   localparam int WEIGHT_BITS_DEF = 16;

   // Fixed field widths of the channels and the control register.
   localparam int CMD_W    = 2;
   localparam int NODE_W   = 6;
   localparam int WEIGHT_W = 16;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 7;

   localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 7'd64;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD    = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_QUERY  = 2'd2,
      CMD_LIST   = 2'd3
   } command_type;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_EDGE = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_RANGE   = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 3'd4;

endpackage
`default_nettype wire

>>> rtl/alist_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Adjacency list channels
// Valid/ready channels for commands into the edge store and results out.
// ----------------------------------------------------------------------------
interface alist_req_if import alist_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [CMD_W-1:0]           command;
   logic [NODE_W-1:0]          from_node;
   logic [NODE_W-1:0]          to_node;
   logic signed [WEIGHT_W-1:0] edge_weight;

   modport source (output valid, command, from_node, to_node, edge_weight,
                   input ready);
   modport sink   (input valid, command, from_node, to_node, edge_weight,
                   output ready);
endinterface

interface alist_rsp_if import alist_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [STATUS_W-1:0]        status;
   logic [NODE_W-1:0]          neighbor_node;
   logic signed [WEIGHT_W-1:0] found_weight;
   logic                       last;

   modport source (output valid, status, neighbor_node, found_weight, last,
                   input ready);
   modport sink   (input valid, status, neighbor_node, found_weight, last,
                   output ready);
endinterface
`default_nettype wire

>>> rtl/adjacency_list_edge_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Adjacency list edge store
// Directed graph with one bounded, ordered list of (target, weight) entries
// per node, kept in a synchronous entry memory and a list length memory.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Moves
//  --------  ---------  ----------------------------------------------------
//  req_chan  in         command, from_node, to_node, edge_weight
//  rsp_chan  out        status, neighbor_node, found_weight, last
//  csr_*     in         node_count write (write enable and data, no read)
//
// An add and every error pass through acceptance, then the list length
// lookup. Query, remove and neighbor listing read one list entry per cycle
// through the single read port of the entry memory, except where a stalled
// result channel holds the scan; a remove then moves each later entry down
// one place at one entry per cycle. Reset is synchronous. After reset the
// length memory is cleared one node per cycle, while no command is accepted.
// A stalled result channel holds the scan only where it has a result to put;
// a new command can be accepted while the last result of the previous one
// still waits.
//
module adjacency_list_edge_store import alist_pkg::*; #(
   parameter int NODES       = NODES_DEF,
   parameter int MAX_DEGREE  = MAX_DEGREE_DEF,
   parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   alist_req_if.sink               req_chan,
   alist_rsp_if.source             rsp_chan,
   input  wire logic               csr_wr_en,
   input  wire logic [COUNT_W-1:0] csr_wr_data
);

   // Node numbers carry NODE_W bits, so only the first 2**NODE_W nodes can
   // ever be addressed; storage is sized for those alone.
   localparam int LEN_DEPTH   = (NODES < (1 << NODE_W)) ? NODES : (1 << NODE_W);
   localparam int SRC_W       = $clog2(LEN_DEPTH);
   localparam int ENTRY_DEPTH = LEN_DEPTH * MAX_DEGREE;
   localparam int ADDR_W      = $clog2(ENTRY_DEPTH);
   localparam int LEN_W       = $clog2(MAX_DEGREE + 1);
   localparam int ENTRY_W     = NODE_W + WEIGHT_BITS;

   localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(MAX_DEGREE);
   localparam logic [SRC_W-1:0] CLR_LAST = SRC_W'(LEN_DEPTH - 1);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOK,
      S_SCAN,
      S_SHIFT
   } state_type;

   // Control register.
   logic [COUNT_W-1:0] node_count_ff;

   // Sequencer state and the command being worked on.
   state_type              state_ff, state_in;
   logic [SRC_W-1:0]       clr_ff, clr_in;
   logic [LEN_W-1:0]       idx_ff, idx_in;
   command_type            cmd_ff;
   logic [NODE_W-1:0]      dst_ff;
   logic [WEIGHT_BITS-1:0] wt_ff;
   logic [ADDR_W-1:0]      base_ff;
   logic [SRC_W-1:0]       src_ff;
   logic                   bad_ff;

   // Result register.
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]        rsp_status_ff;
   logic [NODE_W-1:0]          rsp_node_ff;
   logic signed [WEIGHT_W-1:0] rsp_weight_ff;
   logic                       rsp_last_ff;

   // Memories and their ports.
   logic [LEN_W-1:0]   len_mem [LEN_DEPTH];
   logic [LEN_W-1:0]   len_rd_ff;
   logic               len_re;
   logic               len_we;
   logic [SRC_W-1:0]   len_waddr;
   logic [LEN_W-1:0]   len_wdata;

   logic [ENTRY_W-1:0] ent_mem [ENTRY_DEPTH];
   logic [ENTRY_W-1:0] ent_rd_ff;
   logic               ent_re;
   logic [ADDR_W-1:0]  ent_raddr;
   logic               ent_we;
   logic [ADDR_W-1:0]  ent_waddr;
   logic [ENTRY_W-1:0] ent_wdata;

   // Derived values.
   logic                       req_fire;
   logic                       can_put;
   logic                       src_ok, dst_ok, bad_in;
   logic signed [31:0]         w_in_ext;
   logic [NODE_W-1:0]          rd_tgt;
   logic [WEIGHT_BITS-1:0]     rd_wt;
   logic signed [31:0]         w_out_ext;
   logic [LEN_W-1:0]           nxt_idx;

   logic                       put_en;
   logic [STATUS_W-1:0]        put_status;
   logic [NODE_W-1:0]          put_node;
   logic signed [WEIGHT_W-1:0] put_weight;
   logic                       put_last;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;

   // The result register can take a new result when it is empty or its
   // current result leaves in this cycle.
   assign can_put = !rsp_valid_ff || rsp_chan.ready;

   // A node is in range below both node_count and NODES. Neighbor listing
   // only checks the source node.
   assign src_ok = ({1'b0, req_chan.from_node} < node_count_ff) &&
                   (int'(req_chan.from_node) < NODES);
   assign dst_ok = ({1'b0, req_chan.to_node} < node_count_ff) &&
                   (int'(req_chan.to_node) < NODES);
   assign bad_in = !src_ok ||
                   ((command_type'(req_chan.command) != CMD_LIST) && !dst_ok);

   // The stored weight keeps the low WEIGHT_BITS bits of the sign-extended
   // input; on the way out it is sign-extended back and cut to 16 bits.
   assign w_in_ext  = 32'(req_chan.edge_weight);
   assign rd_tgt    = ent_rd_ff[ENTRY_W-1 -: NODE_W];
   assign rd_wt     = ent_rd_ff[WEIGHT_BITS-1:0];
   assign w_out_ext = 32'(signed'(rd_wt));

   assign nxt_idx = idx_ff + LEN_W'(1);

   assign len_re = req_fire && src_ok;

   // Sequencer next-state and memory control.
   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      idx_in     = idx_ff;
      put_en     = 1'b0;
      put_status = STATUS_OK;
      put_node   = '0;
      put_weight = '0;
      put_last   = 1'b1;
      len_we     = 1'b0;
      len_waddr  = src_ff;
      len_wdata  = len_rd_ff - LEN_W'(1);
      ent_re     = 1'b0;
      ent_raddr  = base_ff + ADDR_W'(nxt_idx);
      ent_we     = 1'b0;
      ent_waddr  = base_ff + ADDR_W'(idx_ff - LEN_W'(1));
      ent_wdata  = ent_rd_ff;

      case (state_ff)
         S_CLEAR: begin
            len_we    = 1'b1;
            len_waddr = clr_ff;
            len_wdata = '0;
            if (clr_ff == CLR_LAST) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + SRC_W'(1);
            end
         end

         S_IDLE: begin
            if (req_fire) begin
               state_in = S_LOOK;
            end
         end

         // The list length of the source node is now in len_rd_ff.
         S_LOOK: begin
            if (bad_ff) begin
               if (can_put) begin
                  put_en     = 1'b1;
                  put_status = STATUS_RANGE;
                  state_in   = S_IDLE;
               end
            end else if (cmd_ff == CMD_ADD) begin
               if (can_put) begin
                  put_en   = 1'b1;
                  state_in = S_IDLE;
                  if (len_rd_ff == LEN_MAX) begin
                     put_status = STATUS_FULL;
                  end else begin
                     ent_we    = 1'b1;
                     ent_waddr = base_ff + ADDR_W'(len_rd_ff);
                     ent_wdata = {dst_ff, wt_ff};
                     len_we    = 1'b1;
                     len_wdata = len_rd_ff + LEN_W'(1);
                  end
               end
            end else if (len_rd_ff == '0) begin
               if (can_put) begin
                  put_en     = 1'b1;
                  put_status = (cmd_ff == CMD_LIST) ? STATUS_EMPTY : STATUS_NO_EDGE;
                  state_in   = S_IDLE;
               end
            end else begin
               ent_re    = 1'b1;
               ent_raddr = base_ff;
               idx_in    = '0;
               state_in  = S_SCAN;
            end
         end

         // Entry idx_ff of the list is now in ent_rd_ff.
         S_SCAN: begin
            if (cmd_ff == CMD_LIST) begin
               if (can_put) begin
                  put_en     = 1'b1;
                  put_node   = rd_tgt;
                  put_weight = w_out_ext[WEIGHT_W-1:0];
                  put_last   = (nxt_idx == len_rd_ff);
                  if (nxt_idx == len_rd_ff) begin
                     state_in = S_IDLE;
                  end else begin
                     ent_re = 1'b1;
                     idx_in = nxt_idx;
                  end
               end
            end else if (rd_tgt == dst_ff) begin
               if (can_put) begin
                  put_en     = 1'b1;
                  put_node   = dst_ff;
                  put_weight = w_out_ext[WEIGHT_W-1:0];
                  if (cmd_ff == CMD_QUERY) begin
                     state_in = S_IDLE;
                  end else if (nxt_idx < len_rd_ff) begin
                     ent_re   = 1'b1;
                     idx_in   = nxt_idx;
                     state_in = S_SHIFT;
                  end else begin
                     // The match was the final entry: only the length shrinks.
                     len_we   = 1'b1;
                     state_in = S_IDLE;
                  end
               end
            end else if (nxt_idx < len_rd_ff) begin
               ent_re = 1'b1;
               idx_in = nxt_idx;
            end else if (can_put) begin
               put_en     = 1'b1;
               put_status = STATUS_NO_EDGE;
               state_in   = S_IDLE;
            end
         end

         // Move entry idx_ff down one place while reading the next one.
         S_SHIFT: begin
            ent_we = 1'b1;
            if (nxt_idx < len_rd_ff) begin
               ent_re = 1'b1;
               idx_in = nxt_idx;
            end else begin
               len_we   = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = put_en || (rsp_valid_ff && !rsp_chan.ready);

   // Sequencer state, captured command and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end

      if (req_fire) begin
         cmd_ff  <= command_type'(req_chan.command);
         dst_ff  <= req_chan.to_node;
         wt_ff   <= w_in_ext[WEIGHT_BITS-1:0];
         src_ff  <= req_chan.from_node[SRC_W-1:0];
         base_ff <= ADDR_W'(int'(req_chan.from_node[SRC_W-1:0]) * MAX_DEGREE);
         bad_ff  <= bad_in;
      end

      if (put_en) begin
         rsp_status_ff <= put_status;
         rsp_node_ff   <= put_node;
         rsp_weight_ff <= put_weight;
         rsp_last_ff   <= put_last;
      end
   end

   // Node count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RESET;
      end else if (csr_wr_en) begin
         node_count_ff <= csr_wr_data;
      end
   end

   // List length memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (len_we) begin
         len_mem[len_waddr] <= len_wdata;
      end
      if (len_re) begin
         len_rd_ff <= len_mem[req_chan.from_node[SRC_W-1:0]];
      end
   end

   // Entry memory: {target, weight}, one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (ent_we) begin
         ent_mem[ent_waddr] <= ent_wdata;
      end
      if (ent_re) begin
         ent_rd_ff <= ent_mem[ent_raddr];
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.neighbor_node = rsp_node_ff;
   assign rsp_chan.found_weight  = rsp_weight_ff;
   assign rsp_chan.last          = rsp_last_ff;

   // An accepted transaction always goes to the length lookup next.
   a_accept_look: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == S_LOOK))
      else $error("accepted transaction did not start a length lookup");

   // A list never grows past its bound.
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_we |-> (len_wdata <= LEN_MAX))
      else $error("list length written beyond MAX_DEGREE");

   // The gap-closing move never writes below the start of the list.
   a_shift_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT) |-> (idx_ff != '0))
      else $error("entry move with index zero");

   // While the length memory is cleared nothing is accepted or returned.
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> (!rsp_valid_ff && !req_chan.ready))
      else $error("channel activity during the clearing pass");

endmodule
`default_nettype wire

>>> tb/sv/adjacency_list_edge_store_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adjacency list edge store testbench
// Drives add, remove, query and neighbor commands into the edge store with
// random gaps and random result stalls. It keeps its own copy of every list
// and checks each result transaction against the predicted one.
// ----------------------------------------------------------------------------
module adjacency_list_edge_store_test;
   import alist_pkg::*;

   // Sizes of the block under test. It is built with its default parameters.
   localparam int NODES      = NODES_DEF;
   localparam int MAX_DEGREE = MAX_DEGREE_DEF;

   // A remove scans, then shifts up to MAX_DEGREE - 1 entries, also after its
   // result is out. Twice that span is allowed before the block counts as idle.
   localparam int SETTLE_CYCLES = 2 * (2 + 2 * MAX_DEGREE);

   // Longest stretch with no transaction on either channel before the run is
   // declared hung. The slowest correct stretch is the clearing pass after
   // reset or a settle pause, both far below this.
   localparam int HANG_LIMIT = 4000;

   // One result transaction as the predictor expects it.
   typedef struct packed {
      logic [STATUS_W-1:0]        status;
      logic [NODE_W-1:0]          node;
      logic signed [WEIGHT_W-1:0] weight;
      logic                       last;
   } edge_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_wr_en = 1'b0;
   logic [COUNT_W-1:0]  csr_wr_data = '0;

   alist_req_if req_if ();
   alist_rsp_if rsp_if ();

   adjacency_list_edge_store dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #2 clock = ~clock;

   // ------------------------------------------------------------------------
   // Predictor state: a shadow copy of every adjacency list and of the
   // node_count register. The weight width equals the channel width, so a
   // stored weight comes back out unchanged.
   // ------------------------------------------------------------------------
   logic [NODE_W-1:0]          shadow_target [NODES][MAX_DEGREE];
   logic signed [WEIGHT_W-1:0] shadow_weight [NODES][MAX_DEGREE];
   int                         shadow_length [NODES];
   int                         active_nodes = NODE_COUNT_RESET;

   edge_result_type pending_results [$];
   int              mismatch_count = 0;

   // When a burst flag is set, that side of the handshake draws no random idle gaps.
   bit req_burst = 1'b0;
   bit rsp_burst = 1'b0;

   initial begin
      for (int n = 0; n < NODES; n++) shadow_length[n] = 0;
   end

   function automatic int idle_draw(bit burst);
      return burst ? 0 : $urandom_range(0, 13);
   endfunction

   function automatic edge_result_type make_result(logic [STATUS_W-1:0] status,
                                                   logic [NODE_W-1:0] node,
                                                   logic signed [WEIGHT_W-1:0] weight,
                                                   logic last);
      edge_result_type r;
      r.status = status;
      r.node   = node;
      r.weight = weight;
      r.last   = last;
      return r;
   endfunction

   // Appends one expected result at the tail of the queue.
   function automatic void queue_expected(edge_result_type r);
      pending_results.insert(pending_results.size(), r);
   endfunction

   // Applies one accepted command to the shadow lists and queues the results
   // the block must produce for it, in order.
   function automatic void apply_command(command_type cmd, logic [NODE_W-1:0] src,
                                         logic [NODE_W-1:0] dst,
                                         logic signed [WEIGHT_W-1:0] weight);
      int limit;
      int len;
      int hit;
      limit = (active_nodes < NODES) ? active_nodes : NODES;
      // Range is checked before anything else; a listing ignores to_node.
      if (int'(src) >= limit || (cmd != CMD_LIST && int'(dst) >= limit)) begin
         queue_expected(make_result(STATUS_RANGE, '0, '0, 1'b1));
         return;
      end
      len = shadow_length[src];
      case (cmd)
         CMD_ADD: begin
            if (len >= MAX_DEGREE) begin
               queue_expected(make_result(STATUS_FULL, '0, '0, 1'b1));
            end else begin
               shadow_target[src][len] = dst;
               shadow_weight[src][len] = weight;
               shadow_length[src] = len + 1;
               queue_expected(make_result(STATUS_OK, '0, '0, 1'b1));
            end
         end
         CMD_LIST: begin
            if (len == 0) begin
               queue_expected(make_result(STATUS_EMPTY, '0, '0, 1'b1));
            end else begin
               for (int i = 0; i < len; i++)
                  queue_expected(make_result(STATUS_OK, shadow_target[src][i],
                                             shadow_weight[src][i],
                                             i == len - 1));
            end
         end
         default: begin
            // Remove and query both look for the first matching target.
            hit = -1;
            for (int i = 0; i < len; i++) begin
               if (hit < 0 && shadow_target[src][i] == dst) hit = i;
            end
            if (hit < 0) begin
               queue_expected(make_result(STATUS_NO_EDGE, '0, '0, 1'b1));
            end else begin
               queue_expected(make_result(STATUS_OK, dst,
                                          shadow_weight[src][hit], 1'b1));
               if (cmd == CMD_REMOVE) begin
                  for (int i = hit; i + 1 < len; i++) begin
                     shadow_target[src][i] = shadow_target[src][i + 1];
                     shadow_weight[src][i] = shadow_weight[src][i + 1];
                  end
                  shadow_length[src] = len - 1;
               end
            end
         end
      endcase
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   // ------------------------------------------------------------------------
   // Command side. Inputs change on the falling edge; the handshake is
   // sampled on the rising edge. valid stays high between back-to-back
   // transactions, so it gets at most one assignment per time step.
   // ------------------------------------------------------------------------
   task automatic send_command(command_type cmd, int src, int dst, int weight);
      int gap;
      gap = idle_draw(req_burst);
      @(negedge clock);
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.command     <= cmd;
      req_if.from_node   <= src[NODE_W-1:0];
      req_if.to_node     <= dst[NODE_W-1:0];
      req_if.edge_weight <= weight[WEIGHT_W-1:0];
      do @(posedge clock); while (!req_if.ready);
      apply_command(cmd, src[NODE_W-1:0], dst[NODE_W-1:0], weight[WEIGHT_W-1:0]);
   endtask

   // Stops sending, waits for every expected result, then lets a remove that
   // may still be shifting entries finish before anything else happens.
   task automatic settle_idle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // node_count is only written while the store is idle.
   task automatic set_node_count(int value);
      settle_idle();
      csr_wr_data <= value[COUNT_W-1:0];
      csr_wr_en   <= 1'b1;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      active_nodes = value & ((1 << COUNT_W) - 1);
   endtask

   // ------------------------------------------------------------------------
   // Result side. Each result transaction is held off by a random stall, then
   // compared field by field with the oldest expectation.
   // ------------------------------------------------------------------------
   initial begin : result_checker
      int              stall;
      edge_result_type want;
      rsp_if.ready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         stall = idle_draw(rsp_burst);
         if (stall != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result status", rsp_if.status, -1);
         end else begin
            want = pending_results.pop_front();
            if (rsp_if.status !== want.status)
               report_mismatch("status", rsp_if.status, want.status);
            if (rsp_if.neighbor_node !== want.node)
               report_mismatch("neighbor_node", rsp_if.neighbor_node, want.node);
            if (rsp_if.found_weight !== want.weight)
               report_mismatch("found_weight", rsp_if.found_weight, want.weight);
            if (rsp_if.last !== want.last)
               report_mismatch("last", rsp_if.last, want.last);
         end
         @(negedge clock);
      end
   end

   // A run whose count of quiet cycles reaches HANG_LIMIT is declared hung.
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= HANG_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Empty list, missing edge, duplicate targets and extreme weights on one
   // node; remove must take the first match and keep the rest in order.
   task automatic test_basic_commands();
      send_command(CMD_LIST,   0, 0, 0);
      send_command(CMD_QUERY,  0, 5, 0);
      send_command(CMD_REMOVE, 0, 5, 0);
      send_command(CMD_ADD,    0, 63, 32767);
      send_command(CMD_ADD,    0, 0, -32768);
      send_command(CMD_ADD,    0, 63, 1);
      send_command(CMD_QUERY,  0, 63, 0);
      send_command(CMD_REMOVE, 0, 63, 0);
      send_command(CMD_LIST,   0, 0, 0);
   endtask

   // Fills the highest node to MAX_DEGREE, then tries one more add, lists the
   // whole list, and removes an entry from the middle.
   task automatic test_full_list();
      for (int i = 0; i < MAX_DEGREE; i++)
         send_command(CMD_ADD, NODES - 1, (i * 5) % NODES, -1 - i * 2000);
      send_command(CMD_ADD,    NODES - 1, 1, 7);
      send_command(CMD_LIST,   NODES - 1, 0, 0);
      send_command(CMD_REMOVE, NODES - 1, 35, 0);
      send_command(CMD_QUERY,  NODES - 1, 40, 0);
   endtask

   // With one node in use, any other source or target is out of range; a
   // listing only looks at the source. With zero nodes nothing is in range.
   task automatic test_node_range();
      set_node_count(1);
      send_command(CMD_ADD,   0, 1, 3);
      send_command(CMD_QUERY, 1, 0, 0);
      send_command(CMD_LIST,  1, 0, 0);
      send_command(CMD_LIST,  0, 63, 0);
      set_node_count(0);
      send_command(CMD_QUERY, 0, 0, 0);
      send_command(CMD_LIST,  0, 0, 0);
   endtask

   // Mostly well-formed traffic on a few hot nodes and targets, so lists fill
   // up, matches are found and removes shift entries; the rest is noise over
   // the full field ranges. Each phase sets its own node_count first.
   task automatic test_random_traffic();
      int          phase_counts [10];
      int          hot_node [3];
      int          hot_target [4];
      int          limit;
      int          items;
      int          pick;
      int          src;
      int          dst;
      int          weight;
      command_type cmd;
      phase_counts = '{64, 127, 2, 0, 64, 1, 16, 0, 64, 0};
      for (int phase = 0; phase < 10; phase++) begin
         // Entries left at 0 get a random count in the middle of the range.
         if (phase == 3 || phase == 7 || phase == 9)
            set_node_count($urandom_range(3, 63));
         else
            set_node_count(phase_counts[phase]);
         limit = (active_nodes < NODES) ? active_nodes : NODES;
         for (int i = 0; i < 3; i++)
            hot_node[i] = (limit > 0) ? $urandom_range(0, limit - 1) : $urandom_range(0, 63);
         for (int i = 0; i < 4; i++)
            hot_target[i] = (limit > 0) ? $urandom_range(0, limit - 1) : $urandom_range(0, 63);
         req_burst = ($urandom_range(0, 3) == 0);
         rsp_burst = ($urandom_range(0, 3) == 0);
         items = 47;
         for (int n = 0; n < items; n++) begin
            weight = $urandom_range(0, 65535);
            if ($urandom_range(0, 15) == 0) weight = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
            if ($urandom_range(0, 99) < 12) begin
               cmd = command_type'($urandom_range(0, 3));
               src = $urandom_range(0, 63);
               dst = $urandom_range(0, 63);
            end else begin
               pick = $urandom_range(0, 99);
               if (pick < 40)      cmd = CMD_ADD;
               else if (pick < 62) cmd = CMD_REMOVE;
               else if (pick < 82) cmd = CMD_QUERY;
               else                cmd = CMD_LIST;
               src = hot_node[$urandom_range(0, 2)];
               dst = hot_target[$urandom_range(0, 3)];
            end
            send_command(cmd, src, dst, weight);
         end
      end
      req_burst = 1'b0;
      rsp_burst = 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      req_if.valid       = 1'b0;
      req_if.command     = CMD_ADD;
      req_if.from_node   = '0;
      req_if.to_node     = '0;
      req_if.edge_weight = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The register is written once right after reset with its reset value.
      set_node_count(NODE_COUNT_RESET);
      test_basic_commands();
      test_full_list();
      test_node_range();
      test_random_traffic();

      settle_idle();
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/alist_pkg.sv
rtl/alist_if.sv
rtl/adjacency_list_edge_store.sv
tb/sv/adjacency_list_edge_store_test.sv
